>>> src/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

  // Build-time configuration
  localparam int CORDIC_STAGES    = 16;
  localparam int PHASE_BITS       = 16;
  localparam int SAMPLE_FRAC_BITS = 8;

  localparam int NSTG  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int SHW   = $clog2(NSTG);

  // Field widths
  localparam int IN_W    = 8;
  localparam int OUT_W   = 16;
  localparam int THR_W   = 16;
  localparam int SHIFT_W = 5;
  localparam int XW      = IN_W + 1;
  localparam int XOFS    = 127;
  localparam int PW      = 2 * (XW - 1) + 1;

  // DC tracker
  localparam int AVG_FRAC     = 23;
  localparam int AVG_W        = 32;
  localparam int DW           = AVG_W + 1;
  localparam int DC_OUT_SHIFT = AVG_FRAC - SAMPLE_FRAC_BITS;
  localparam int VW_RAW       = DW - DC_OUT_SHIFT + 1;
  localparam int LANE_W       = 18;
  localparam int VW           = (VW_RAW > LANE_W) ? VW_RAW : LANE_W + 1;
  localparam int LANE_MAX     = 2 ** (LANE_W - 1) - 1;
  localparam int LANE_MIN     = -(2 ** (LANE_W - 1));

  // Mixer / CORDIC
  localparam int PRW = 2 * LANE_W;
  localparam int ZW  = 2 * LANE_W + 3;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  // Config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONJ_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_SHF  = 3'd4;

  typedef struct packed {
    logic               dc_en;
    logic               conj_en;
    logic               sq_en;
    logic [THR_W-1:0]   sq_thr;
    logic [SHIFT_W-1:0] dc_shift;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dc_en: 1'b0, conj_en: 1'b1, sq_en: 1'b0,
    sq_thr: THR_W'(0), dc_shift: SHIFT_W'(17)
  };

  // Per-request sideband carried down the pipeline
  typedef struct packed {
    logic valid;
    logic sq;
    logic last;
    logic zero;
  } meta_t;

  // atan(2^-i), pi = 2^31
  function automatic logic [31:0] atan_full(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Micro-rotation angle rounded to PHASE_BITS
  function automatic logic [PHASE_BITS-1:0] cordic_step(input int i);
    logic [32:0] s;
    s = {1'b0, atan_full(i)} + (33'd1 << (31 - PHASE_BITS));
    return s[31 -: PHASE_BITS];
  endfunction

endpackage

`default_nettype wire

>>> src/ifd_if.sv
`default_nettype none

interface ifd_in_if;
  logic                     valid;
  logic                     ready;
  logic [ifd_pkg::IN_W-1:0] i_byte;
  logic [ifd_pkg::IN_W-1:0] q_byte;
  logic                     last_in;

  modport source (output valid, i_byte, q_byte, last_in, input ready);
  modport sink   (input valid, i_byte, q_byte, last_in, output ready);
endinterface

interface ifd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ifd_pkg::OUT_W-1:0] phase_diff;
  logic                             squelched;
  logic                             last_out;

  modport source (output valid, phase_diff, squelched, last_out, input ready);
  modport sink   (input valid, phase_diff, squelched, last_out, output ready);
endinterface

`default_nettype wire

>>> src/ifd_front.sv
`default_nettype none

module ifd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic                               in_last,
  input  logic [ifd_pkg::IN_W-1:0]           in_i,
  input  logic [ifd_pkg::IN_W-1:0]           in_q,
  input  ifd_pkg::cfg_t                      cfg,
  output ifd_pkg::meta_t                     meta_c,
  output logic signed [ifd_pkg::LANE_W-1:0]  cur_i,
  output logic signed [ifd_pkg::LANE_W-1:0]  cur_q,
  output logic signed [ifd_pkg::LANE_W-1:0]  prev_i,
  output logic signed [ifd_pkg::LANE_W-1:0]  prev_q
);
  import ifd_pkg::*;

  function automatic logic signed [AVG_W-1:0] dc_update(
    input logic signed [XW-1:0]    x,
    input logic signed [AVG_W-1:0] avg,
    input logic [SHIFT_W-1:0]      sh
  );
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] s;
    d = (DW'(x) <<< AVG_FRAC) - DW'(avg);
    s = d >>> sh;
    return avg + AVG_W'(s);
  endfunction

  function automatic logic signed [LANE_W-1:0] lane_out(
    input logic signed [XW-1:0]    x,
    input logic signed [AVG_W-1:0] avg,
    input logic                    dc_en,
    input logic                    neg
  );
    logic signed [DW-1:0] d;
    logic signed [VW-1:0] v;
    logic signed [LANE_W-1:0] r;
    d = (DW'(x) <<< AVG_FRAC) - DW'(avg);
    if (dc_en) begin
      v = VW'(d >>> DC_OUT_SHIFT);
    end else begin
      v = VW'(x) <<< SAMPLE_FRAC_BITS;
    end
    if (neg) begin
      v = -v;
    end
    if (v > VW'(LANE_MAX)) begin
      r = LANE_W'(LANE_MAX);
    end else if (v < VW'(LANE_MIN)) begin
      r = LANE_W'(LANE_MIN);
    end else begin
      r = LANE_W'(v);
    end
    return r;
  endfunction

  // Stage A: offset removal and power squelch
  logic signed [XW-1:0]   xi_a, xq_a;
  logic signed [2*XW-1:0] pi_a, pq_a;
  logic [PW-1:0]          pwr_a;
  logic                   sq_a;
  meta_t                  meta_a_r;
  logic signed [XW-1:0]   xi_a_r, xq_a_r;

  always_comb begin
    xi_a  = $signed({1'b0, in_i}) - XW'(XOFS);
    xq_a  = $signed({1'b0, in_q}) - XW'(XOFS);
    pi_a  = xi_a * xi_a;
    pq_a  = xq_a * xq_a;
    pwr_a = PW'($unsigned(pi_a)) + PW'($unsigned(pq_a));
    sq_a  = cfg.sq_en && (pwr_a < PW'(cfg.sq_thr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_a_r <= '0;
    end else if (adv) begin
      meta_a_r <= '{valid: in_valid, sq: sq_a, last: in_last, zero: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xi_a_r <= sq_a ? '0 : xi_a;
      xq_a_r <= sq_a ? '0 : xq_a;
    end
  end

  // Stage B: DC tracker update; avg_*_r then belongs to the request in stage B
  logic signed [AVG_W-1:0] avg_i_r, avg_q_r, avg_i_nxt, avg_q_nxt;
  meta_t                   meta_b_r;
  logic signed [XW-1:0]    xi_b_r, xq_b_r;

  always_comb begin
    avg_i_nxt = dc_update(xi_a_r, avg_i_r, cfg.dc_shift);
    avg_q_nxt = dc_update(xq_a_r, avg_q_r, cfg.dc_shift);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_i_r  <= '0;
      avg_q_r  <= '0;
      meta_b_r <= '0;
    end else if (adv) begin
      meta_b_r <= meta_a_r;
      if (meta_a_r.valid && cfg.dc_en) begin
        avg_i_r <= avg_i_nxt;
        avg_q_r <= avg_q_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xi_b_r <= xi_a_r;
      xq_b_r <= xq_a_r;
    end
  end

  // Stage C: DC removal, conjugate, saturate; keep previous sample
  logic signed [LANE_W-1:0] ci_nxt, cq_nxt;
  logic signed [LANE_W-1:0] cur_i_r, cur_q_r, prev_i_r, prev_q_r;
  meta_t                    meta_c_r;

  always_comb begin
    ci_nxt = lane_out(xi_b_r, avg_i_r, cfg.dc_en, 1'b0);
    cq_nxt = lane_out(xq_b_r, avg_q_r, cfg.dc_en, cfg.conj_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_i_r  <= '0;
      cur_q_r  <= '0;
      prev_i_r <= '0;
      prev_q_r <= '0;
      meta_c_r <= '0;
    end else if (adv) begin
      meta_c_r <= meta_b_r;
      if (meta_b_r.valid) begin
        prev_i_r <= cur_i_r;
        prev_q_r <= cur_q_r;
        cur_i_r  <= ci_nxt;
        cur_q_r  <= cq_nxt;
      end
    end
  end

  assign meta_c = meta_c_r;
  assign cur_i  = cur_i_r;
  assign cur_q  = cur_q_r;
  assign prev_i = prev_i_r;
  assign prev_q = prev_q_r;

endmodule

`default_nettype wire

>>> src/ifd_mix.sv
`default_nettype none

module ifd_mix (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  ifd_pkg::meta_t                       meta_i,
  input  logic signed [ifd_pkg::LANE_W-1:0]    cur_i,
  input  logic signed [ifd_pkg::LANE_W-1:0]    cur_q,
  input  logic signed [ifd_pkg::LANE_W-1:0]    prev_i,
  input  logic signed [ifd_pkg::LANE_W-1:0]    prev_q,
  output ifd_pkg::meta_t                       meta_o,
  output logic signed [ifd_pkg::ZW-1:0]        x_o,
  output logic signed [ifd_pkg::ZW-1:0]        y_o,
  output logic [ifd_pkg::PHASE_BITS-1:0]       ang_o
);
  import ifd_pkg::*;

  // Stage D: cur * conj(prev), four partial products
  meta_t                 meta_d_r;
  logic signed [PRW-1:0] p_rr_r, p_qq_r, p_qi_r, p_iq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_d_r <= '0;
    end else if (adv) begin
      meta_d_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rr_r <= cur_i * prev_i;
      p_qq_r <= cur_q * prev_q;
      p_qi_r <= cur_q * prev_i;
      p_iq_r <= cur_i * prev_q;
    end
  end

  // Stage E: sum, zero test, fold left half plane into the right
  logic signed [ZW-1:0]     zr, zi, x_nxt, y_nxt;
  logic [PHASE_BITS-1:0]    ang_nxt;
  meta_t                    meta_nxt;
  meta_t                    meta_e_r;
  logic signed [ZW-1:0]     x_e_r, y_e_r;
  logic [PHASE_BITS-1:0]    ang_e_r;

  always_comb begin
    zr = ZW'(p_rr_r) + ZW'(p_qq_r);
    zi = ZW'(p_qi_r) - ZW'(p_iq_r);
    meta_nxt      = meta_d_r;
    meta_nxt.zero = (zr == '0) && (zi == '0);
    if (zr[ZW-1]) begin
      if (!zi[ZW-1]) begin
        x_nxt   = zi;
        y_nxt   = -zr;
        ang_nxt = QUARTER;
      end else begin
        x_nxt   = -zi;
        y_nxt   = zr;
        ang_nxt = PHASE_BITS'(0) - QUARTER;
      end
    end else begin
      x_nxt   = zr;
      y_nxt   = zi;
      ang_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_e_r <= '0;
    end else if (adv) begin
      meta_e_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_e_r   <= x_nxt;
      y_e_r   <= y_nxt;
      ang_e_r <= ang_nxt;
    end
  end

  assign meta_o = meta_e_r;
  assign x_o    = x_e_r;
  assign y_o    = y_e_r;
  assign ang_o  = ang_e_r;

endmodule

`default_nettype wire

>>> src/ifd_cell.sv
`default_nettype none

module ifd_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic [ifd_pkg::SHW-1:0]           sh,
  input  logic [ifd_pkg::PHASE_BITS-1:0]    step,
  input  ifd_pkg::meta_t                    meta_i,
  input  logic signed [ifd_pkg::ZW-1:0]     x_i,
  input  logic signed [ifd_pkg::ZW-1:0]     y_i,
  input  logic [ifd_pkg::PHASE_BITS-1:0]    ang_i,
  output ifd_pkg::meta_t                    meta_o,
  output logic signed [ifd_pkg::ZW-1:0]     x_o,
  output logic signed [ifd_pkg::ZW-1:0]     y_o,
  output logic [ifd_pkg::PHASE_BITS-1:0]    ang_o
);
  import ifd_pkg::*;

  logic signed [ZW-1:0]  dx, dy, x_nxt, y_nxt;
  logic [PHASE_BITS-1:0] ang_nxt;
  meta_t                 meta_r;
  logic signed [ZW-1:0]  x_r, y_r;
  logic [PHASE_BITS-1:0] ang_r;

  // One vectoring micro-rotation: drive y toward zero
  always_comb begin
    dx = y_i >>> sh;
    dy = x_i >>> sh;
    if (!y_i[ZW-1]) begin
      x_nxt   = x_i + dx;
      y_nxt   = y_i - dy;
      ang_nxt = ang_i + step;
    end else begin
      x_nxt   = x_i - dx;
      y_nxt   = y_i + dy;
      ang_nxt = ang_i - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (adv) begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign meta_o = meta_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign ang_o  = ang_r;

endmodule

`default_nettype wire

>>> src/iq_fm_discriminator_unit.sv
// FM quadrature discriminator for raw 8-bit I/Q pairs.
// in_ch : one request per sample (i_byte, q_byte, last_in), valid/ready.
// out_ch: one request per sample (phase_diff, squelched, last_out), pi = 32768.
// cfg_* : write-only registers, taken on any clock with cfg_we high; write
//         them only while no sample is in flight.
// Pipeline: 3 front stages (offset + squelch, DC tracker, DC removal +
//   conjugate + saturate), 2 mixer stages (products, sum + quadrant fold),
//   one CORDIC cell per micro-rotation (16 by default), one output register.
// Throughput: one sample per clock; the whole chain moves on a single
//   advance strobe, so nothing limits the rate but the sink.
// Stall: while out_ch holds a request that is not taken, every stage
//   freezes and in_ch.ready is low; nothing is dropped or repeated.
// Reset (rst_n low, synchronous): registers return to defaults (conjugate
//   on, DC and squelch off, rate shift 17), DC averages and the previous
//   sample are cleared, and the pipeline empties. The first sample after
//   reset therefore gives phase 0.
// last_in rides along unchanged; it does not reset the previous sample.
`default_nettype none

module iq_fm_discriminator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  ifd_in_if.sink                            in_ch,
  ifd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ifd_pkg::THR_W-1:0]         cfg_wdata
);
  import ifd_pkg::*;

  // Global advance: move everything when the output slot is free or taken
  logic adv;
  logic out_valid_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;

  // Configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DC_EN:   cfg_r.dc_en    <= cfg_wdata[0];
        CFG_CONJ_EN: cfg_r.conj_en  <= cfg_wdata[0];
        CFG_SQ_EN:   cfg_r.sq_en    <= cfg_wdata[0];
        CFG_SQ_THR:  cfg_r.sq_thr   <= cfg_wdata[THR_W-1:0];
        CFG_DC_SHF:  cfg_r.dc_shift <= cfg_wdata[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: squelch, DC tracking, conjugate; holds current/previous sample
  meta_t                    meta_c;
  logic signed [LANE_W-1:0] cur_i, cur_q, prev_i, prev_q;

  ifd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_in),
    .in_i     (in_ch.i_byte),
    .in_q     (in_ch.q_byte),
    .cfg      (cfg_r),
    .meta_c   (meta_c),
    .cur_i    (cur_i),
    .cur_q    (cur_q),
    .prev_i   (prev_i),
    .prev_q   (prev_q)
  );

  // Chain taps: index 0 is the mixer output, index k the output of cell k-1
  meta_t                 meta_s [0:NSTG];
  logic signed [ZW-1:0]  x_s    [0:NSTG];
  logic signed [ZW-1:0]  y_s    [0:NSTG];
  logic [PHASE_BITS-1:0] ang_s  [0:NSTG];

  ifd_mix u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .meta_i (meta_c),
    .cur_i  (cur_i),
    .cur_q  (cur_q),
    .prev_i (prev_i),
    .prev_q (prev_q),
    .meta_o (meta_s[0]),
    .x_o    (x_s[0]),
    .y_o    (y_s[0]),
    .ang_o  (ang_s[0])
  );

  // CORDIC row: cell k shifts by k and adds or subtracts the k-th arctangent
  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    ifd_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .sh     (SHW'(k)),
      .step   (cordic_step(k)),
      .meta_i (meta_s[k]),
      .x_i    (x_s[k]),
      .y_i    (y_s[k]),
      .ang_i  (ang_s[k]),
      .meta_o (meta_s[k+1]),
      .x_o    (x_s[k+1]),
      .y_o    (y_s[k+1]),
      .ang_o  (ang_s[k+1])
    );
  end

  // Scale the angle to 16 bits (keep top bits, or pad below)
  logic [OUT_W-1:0] ph16;

  if (PHASE_BITS >= OUT_W) begin : g_ph_trunc
    assign ph16 = ang_s[NSTG][PHASE_BITS-1 -: OUT_W];
  end else begin : g_ph_pad
    assign ph16 = {ang_s[NSTG], {(OUT_W - PHASE_BITS){1'b0}}};
  end

  // Output register; a zero product reports phase 0
  logic [OUT_W-1:0] out_phase_r;
  logic             out_sq_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= meta_s[NSTG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r <= meta_s[NSTG].zero ? '0 : ph16;
      out_sq_r    <= meta_s[NSTG].sq;
      out_last_r  <= meta_s[NSTG].last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.phase_diff = $signed(out_phase_r);
  assign out_ch.squelched  = out_sq_r;
  assign out_ch.last_out   = out_last_r;

`ifndef ASSERT_OFF
  // Whenever the current sample is replaced, the old one becomes the previous
  a_prev_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_i != $past(cur_i)) |-> (prev_i == $past(cur_i)))
    else $error("previous sample did not take the replaced current sample");

  // The zero flag from the mixer must match an all-zero vector
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    meta_s[0].zero |-> ((x_s[0] == '0) && (y_s[0] == '0)))
    else $error("zero flag set on a nonzero vector");

  // Vectoring keeps x non-negative; checked at the end of the row
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    meta_s[NSTG].valid |-> !x_s[NSTG][ZW-1])
    else $error("CORDIC x went negative");
`endif

endmodule

`default_nettype wire
